@@ rtl/fsc_pkg.sv @@
// Shared constants and types for the filled circle span generator.
package fsc_pkg;

    // Circle limits and result cap.
    localparam int MAX_RADIUS  = 63;
    localparam int COORD_RANGE = 1024;
    localparam int RESULT_CAP  = 64;

    // Depth of the job queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result counter width.
    localparam int CNT_W = $clog2(RESULT_CAP);

    typedef logic [9:0]         t_coord;
    typedef logic [5:0]         t_radius;
    typedef logic signed [11:0] t_pos;

    // One circle job, as held in the queue.
    typedef struct packed {
        t_coord  cx;
        t_coord  cy;
        t_radius rad;
    } t_job;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

@@ rtl/filled_circle_span_generator_top.sv @@
// A circle's job leaves the queue and is loaded into the recurrence registers before its
// span groups are registered, one per cycle while the single recurrence unit steps, plus
// a load step per circle; radius r gives about r/sqrt(2)+1 groups, at most 64.
// A two-entry job queue lets new circles be taken while the recurrence runs.
// Reset is synchronous and active low; it empties the queue and idles the back end.
// Results are strobed for one cycle each and cannot be held off by the receiver.
module filled_circle_span_generator_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  fsc_pkg::t_coord  i_center_x,
    input  fsc_pkg::t_coord  i_center_y,
    input  fsc_pkg::t_radius i_radius,
    output logic             o_valid,
    output fsc_pkg::t_pos    o_wide_left,
    output fsc_pkg::t_pos    o_wide_right,
    output fsc_pkg::t_pos    o_narrow_left,
    output fsc_pkg::t_pos    o_narrow_right,
    output fsc_pkg::t_pos    o_wide_row_below,
    output fsc_pkg::t_pos    o_wide_row_above,
    output fsc_pkg::t_pos    o_narrow_row_below,
    output fsc_pkg::t_pos    o_narrow_row_above,
    output logic             o_last_step
);
    import fsc_pkg::*;

    t_job      w_push_job;
    t_job      w_head_job;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    // Front part: transaction acceptance and field clamping.
    fsc_front u_front (
        .start      (start),
        .busy       (busy),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    // Job queue between the two parts.
    fsc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    // Back part: recurrence and span output.
    fsc_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_job              (w_head_job),
        .i_q_status         (w_q_status),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .o_wide_left        (o_wide_left),
        .o_wide_right       (o_wide_right),
        .o_narrow_left      (o_narrow_left),
        .o_narrow_right     (o_narrow_right),
        .o_wide_row_below   (o_wide_row_below),
        .o_wide_row_above   (o_wide_row_above),
        .o_narrow_row_below (o_narrow_row_below),
        .o_narrow_row_above (o_narrow_row_above),
        .o_last_step        (o_last_step)
    );

endmodule

@@ rtl/fsc_front.sv @@
// Front part: accepts circle transactions, clamps their fields and pushes them into the queue.
module fsc_front (
    input  logic              start,
    output logic              busy,
    input  fsc_pkg::t_coord   i_center_x,
    input  fsc_pkg::t_coord   i_center_y,
    input  fsc_pkg::t_radius  i_radius,
    input  fsc_pkg::t_q_status i_q_status,
    output logic              o_push,
    output fsc_pkg::t_job     o_job
);
    import fsc_pkg::*;

    // The block is busy only while the queue has no free entry.
    assign busy   = i_q_status.full;
    assign o_push = start && !i_q_status.full;

    // Clamp the centre to the coordinate range and the radius to its maximum.
    always_comb begin
        o_job.cx  = (int'(i_center_x) >= COORD_RANGE) ? t_coord'(COORD_RANGE - 1) : i_center_x;
        o_job.cy  = (int'(i_center_y) >= COORD_RANGE) ? t_coord'(COORD_RANGE - 1) : i_center_y;
        o_job.rad = (int'(i_radius) > MAX_RADIUS) ? t_radius'(MAX_RADIUS) : i_radius;
    end

endmodule

@@ rtl/fsc_queue.sv @@
// Short job queue that decouples the front part from the span back end.
module fsc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fsc_pkg::t_job      i_job,
    input  logic               i_pop,
    output fsc_pkg::t_job      o_job,
    output fsc_pkg::t_q_status o_status
);
    import fsc_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    // Pointer advance with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
        n_rd_ptr = (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
    end

    // Storage: written at the write pointer, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_job           = r_mem[r_rd_ptr];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (int'(r_count) == QUEUE_DEPTH);

endmodule

@@ rtl/fsc_back.sv @@
// Back part: runs the Andres circle recurrence and emits one span group per step.
module fsc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsc_pkg::t_job      i_job,
    input  fsc_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_valid,
    output fsc_pkg::t_pos      o_wide_left,
    output fsc_pkg::t_pos      o_wide_right,
    output fsc_pkg::t_pos      o_narrow_left,
    output fsc_pkg::t_pos      o_narrow_right,
    output fsc_pkg::t_pos      o_wide_row_below,
    output fsc_pkg::t_pos      o_wide_row_above,
    output fsc_pkg::t_pos      o_narrow_row_below,
    output fsc_pkg::t_pos      o_narrow_row_above,
    output logic               o_last_step
);
    import fsc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                 r_state;
    logic [6:0]             r_x;
    logic signed [7:0]      r_y;
    logic signed [9:0]      r_d;
    t_coord                 r_cx;
    t_coord                 r_cy;
    t_radius                r_rad;
    logic [CNT_W-1:0]       r_count;
    logic                   r_valid;
    logic                   r_last;
    t_pos                   r_wl, r_wr, r_nl, r_nr, r_wrb, r_wra, r_nrb, r_nra;

    logic [6:0]             n_x;
    logic signed [7:0]      n_y;
    logic signed [9:0]      n_d;
    logic signed [9:0]      x10, y10, rad10;
    t_pos                   cx12, cy12, x12, y12;
    logic                   done;

    // Sign-extended views of the loop variables.
    always_comb begin
        x10   = signed'({3'b000, r_x});
        y10   = {{2{r_y[7]}}, r_y};
        rad10 = signed'({4'b0000, r_rad});
        cx12  = signed'({2'b00, r_cx});
        cy12  = signed'({2'b00, r_cy});
        x12   = signed'({5'b00000, r_x});
        y12   = {{4{r_y[7]}}, r_y};
    end

    // One step of the recurrence; the order of the tests decides the move.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_d = r_d;
        priority if (r_d >= x10 + x10) begin
            n_d = r_d - x10 - x10 - 10'sd1;
            n_x = r_x + 7'd1;
        end else if (r_d < (rad10 - y10) + (rad10 - y10)) begin
            n_d = r_d + y10 + y10 - 10'sd1;
            n_y = r_y - 8'sd1;
        end else begin
            n_d = r_d + (y10 - x10 - 10'sd1) + (y10 - x10 - 10'sd1);
            n_y = r_y - 8'sd1;
            n_x = r_x + 7'd1;
        end
        done = (n_y < signed'({1'b0, n_x})) || (int'(r_count) == RESULT_CAP - 1);
    end

    // Take the next job whenever the back part is free.
    assign o_pop = (r_state == S_IDLE) && !i_q_status.empty;

    // Sequencer, loop registers and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cx    <= i_job.cx;
                        r_cy    <= i_job.cy;
                        r_rad   <= i_job.rad;
                        r_x     <= '0;
                        r_y     <= signed'({2'b00, i_job.rad});
                        r_d     <= signed'({4'b0000, i_job.rad}) - 10'sd1;
                        r_count <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_wl    <= cx12 - y12;
                    r_wr    <= cx12 + y12;
                    r_nl    <= cx12 - x12;
                    r_nr    <= cx12 + x12;
                    r_wrb   <= cy12 + x12;
                    r_wra   <= cy12 - x12;
                    r_nrb   <= cy12 + y12;
                    r_nra   <= cy12 - y12;
                    r_last  <= done;
                    r_valid <= 1'b1;
                    r_x     <= n_x;
                    r_y     <= n_y;
                    r_d     <= n_d;
                    r_count <= r_count + CNT_W'(1);
                    if (done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_valid;
    assign o_wide_left        = r_wl;
    assign o_wide_right       = r_wr;
    assign o_narrow_left      = r_nl;
    assign o_narrow_right     = r_nr;
    assign o_wide_row_below   = r_wrb;
    assign o_wide_row_above   = r_wra;
    assign o_narrow_row_below = r_nrb;
    assign o_narrow_row_above = r_nra;
    assign o_last_step        = r_last;

`ifndef SYNTHESIS
    // While stepping, the y offset never falls below the x offset.
    a_run_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RUN |-> r_y >= signed'({1'b0, r_x}))
        else $error("y offset below x offset while stepping");

    // The final span group of a circle is followed by a gap for the next load.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_step |=> !o_valid)
        else $error("result strobe directly after final span group");

    // Taking a job from the queue always starts a circle.
    a_pop_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_RUN)
        else $error("job popped without starting the recurrence");

    // A result strobe only follows a stepping cycle.
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_RUN))
        else $error("result strobe without a recurrence step");
`endif

endmodule

@@ tb/sv/filled_circle_span_generator_top_tb.sv @@
// Self-checking testbench for the filled circle span generator, with its own span predictor.
`timescale 1ns / 1ps

module filled_circle_span_generator_top_tb;
    import fsc_pkg::*;

    // Idle cycles without any transaction before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles allowed after the last expected span group has arrived.
    localparam int DRAIN_CYCLES   = 10;

    // One span group, as the block presents it on its result ports.
    typedef struct packed {
        t_pos wide_left;
        t_pos wide_right;
        t_pos narrow_left;
        t_pos narrow_right;
        t_pos wide_row_below;
        t_pos wide_row_above;
        t_pos narrow_row_below;
        t_pos narrow_row_above;
        logic last_step;
    } t_span_group;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_coord  i_center_x;
    t_coord  i_center_y;
    t_radius i_radius;
    logic    o_valid;
    t_pos    o_wide_left;
    t_pos    o_wide_right;
    t_pos    o_narrow_left;
    t_pos    o_narrow_right;
    t_pos    o_wide_row_below;
    t_pos    o_wide_row_above;
    t_pos    o_narrow_row_below;
    t_pos    o_narrow_row_above;
    logic    o_last_step;

    t_span_group expected_spans[$];
    t_span_group oldest_span;
    int          mismatches;
    int          idle_cycles;

    filled_circle_span_generator_top DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_center_x         (i_center_x),
        .i_center_y         (i_center_y),
        .i_radius           (i_radius),
        .o_valid            (o_valid),
        .o_wide_left        (o_wide_left),
        .o_wide_right       (o_wide_right),
        .o_narrow_left      (o_narrow_left),
        .o_narrow_right     (o_narrow_right),
        .o_wide_row_below   (o_wide_row_below),
        .o_wide_row_above   (o_wide_row_above),
        .o_narrow_row_below (o_narrow_row_below),
        .o_narrow_row_above (o_narrow_row_above),
        .o_last_step        (o_last_step)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run the Andres circle recurrence for one circle and queue every span group it yields.
    task automatic predict_spans(input t_coord cx, input t_coord cy, input t_radius rad);
        int ox;
        int oy;
        int dec;
        int step_x;
        int step_y;
        int groups;
        t_span_group grp;
        ox     = 0;
        oy     = int'(rad);
        dec    = int'(rad) - 1;
        groups = 0;
        while (oy >= ox && groups < RESULT_CAP) begin
            step_x = ox;
            step_y = oy;
            if (dec >= 2 * ox) begin
                dec -= 2 * ox + 1;
                ox  += 1;
            end else if (dec < 2 * (int'(rad) - oy)) begin
                dec += 2 * oy - 1;
                oy  -= 1;
            end else begin
                dec += 2 * (oy - ox - 1);
                oy  -= 1;
                ox  += 1;
            end
            grp.wide_left        = t_pos'(int'(cx) - step_y);
            grp.wide_right       = t_pos'(int'(cx) + step_y);
            grp.narrow_left      = t_pos'(int'(cx) - step_x);
            grp.narrow_right     = t_pos'(int'(cx) + step_x);
            grp.wide_row_below   = t_pos'(int'(cy) + step_x);
            grp.wide_row_above   = t_pos'(int'(cy) - step_x);
            grp.narrow_row_below = t_pos'(int'(cy) + step_y);
            grp.narrow_row_above = t_pos'(int'(cy) - step_y);
            groups++;
            grp.last_step        = (oy < ox) || (groups >= RESULT_CAP);
            expected_spans.push_back(grp);
        end
    endtask

    // Issue one circle. Entered and left just after a falling edge.
    task automatic send_circle(input t_coord cx, input t_coord cy, input t_radius rad,
                               input int gap_limit);
        int gap;
        gap = $urandom_range(0, gap_limit);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        do @(posedge i_clk); while (busy);
        predict_spans(cx, cy, rad);
        @(negedge i_clk);
    endtask

    // Compare one position field and report it if it differs.
    function automatic int check_pos(input string name, input t_pos want, input t_pos got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Every strobed span group is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected span group, expected none, actual wide %0d..%0d",
                         $time, o_wide_left, o_wide_right);
                mismatches++;
            end else begin
                oldest_span = expected_spans.pop_front();
                mismatches += check_pos("wide_left", oldest_span.wide_left, o_wide_left);
                mismatches += check_pos("wide_right", oldest_span.wide_right, o_wide_right);
                mismatches += check_pos("narrow_left", oldest_span.narrow_left,
                                        o_narrow_left);
                mismatches += check_pos("narrow_right", oldest_span.narrow_right,
                                        o_narrow_right);
                mismatches += check_pos("wide_row_below", oldest_span.wide_row_below,
                                        o_wide_row_below);
                mismatches += check_pos("wide_row_above", oldest_span.wide_row_above,
                                        o_wide_row_above);
                mismatches += check_pos("narrow_row_below", oldest_span.narrow_row_below,
                                        o_narrow_row_below);
                mismatches += check_pos("narrow_row_above", oldest_span.narrow_row_above,
                                        o_narrow_row_above);
                if (oldest_span.last_step !== o_last_step) begin
                    $display("%0t: last_step mismatch, expected %0b, actual %0b",
                             $time, oldest_span.last_step, o_last_step);
                    mismatches++;
                end
            end
        end
    end

    // Abandon the run if neither side completes a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("filled_circle_span_generator_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Corner circles: zero radius, small radii, largest radius at every corner, alternating bit patterns.
    task automatic test_directed_extremes();
        send_circle(10'd512,  10'd512,  6'd0,  2);
        send_circle(10'd0,    10'd0,    6'd0,  2);
        send_circle(10'd1023, 10'd1023, 6'd0,  0);
        send_circle(10'd0,    10'd0,    6'd63, 3);
        send_circle(10'd1023, 10'd1023, 6'd63, 0);
        send_circle(10'd0,    10'd1023, 6'd63, 1);
        send_circle(10'd1023, 10'd0,    6'd63, 5);
        send_circle(10'd100,  10'd200,  6'd1,  0);
        send_circle(10'd100,  10'd200,  6'd2,  0);
        send_circle(10'd300,  10'd400,  6'd3,  4);
        send_circle(10'd0,    10'd0,    6'd1,  0);
        send_circle(10'd1023, 10'd1023, 6'd1,  2);
        send_circle(10'd512,  10'd300,  6'd10, 0);
        send_circle(10'd682,  10'd341,  6'd42, 1);
        send_circle(10'd341,  10'd682,  6'd21, 0);
    endtask

    // Random circles; a third of them are small, and some sit against the edges.
    task automatic test_random_circles(input int count, input int gap_limit);
        t_coord  cx;
        t_coord  cy;
        t_radius rad;
        for (int n = 0; n < count; n++) begin
            cx  = ($urandom_range(0, 7) == 0) ? t_coord'($urandom_range(0, 1) * 1023)
                                              : t_coord'($urandom());
            cy  = ($urandom_range(0, 7) == 0) ? t_coord'($urandom_range(0, 1) * 1023)
                                              : t_coord'($urandom());
            rad = ($urandom_range(0, 2) == 0) ? t_radius'($urandom_range(0, 4))
                                              : t_radius'($urandom());
            send_circle(cx, cy, rad, gap_limit);
        end
    endtask

    // Hold off new circles until every outstanding span group has arrived, then resume.
    task automatic test_drain_pause(input int bursts);
        for (int b = 0; b < bursts; b++) begin
            start <= 1'b0;
            do @(negedge i_clk); while (expected_spans.size() != 0);
            test_random_circles($urandom_range(1, 6), 0);
        end
    endtask

    // Reset, run each test in turn, then wait for the last span groups.
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_center_x  = '0;
        i_center_y  = '0;
        i_radius    = '0;
        mismatches  = 0;
        idle_cycles = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_extremes();
        test_random_circles(150, 5);
        test_random_circles(100, 0);
        test_drain_pause(10);
        test_random_circles(115, 5);

        start <= 1'b0;
        while (expected_spans.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_spans.size() == 0) begin
            $display("filled_circle_span_generator_top test passed");
        end else begin
            $display("filled_circle_span_generator_top test failed");
        end
        $finish;
    end

endmodule
